FILE: hw/rtl/bfcs_pkg.sv
// Shared types and constants for the best-fit candidate selector.
package bfcs_pkg;

    localparam int SCORE_W = 42;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic store_en;
        logic load_cand;
        logic scan_en;
        logic decide;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_idle;
        logic cand_last;
        logic out_busy;
    } ctrl_status_t;

endpackage

FILE: hw/rtl/bfcs_item_if.sv
// Input channel carrying cloud points and candidate points.
interface bfcs_item_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic                         last_candidate;

    modport source (
        output valid, cmd, coord_x, coord_y, coord_z, last_candidate,
        input  ready
    );

    modport sink (
        input  valid, cmd, coord_x, coord_y, coord_z, last_candidate,
        output ready
    );
endinterface

FILE: hw/rtl/bfcs_result_if.sv
// Output channel carrying the best candidate of a batch and its score.
interface bfcs_result_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] best_x;
    logic signed [COORD_BITS-1:0] best_y;
    logic signed [COORD_BITS-1:0] best_z;
    logic [bfcs_pkg::SCORE_W-1:0] best_score;

    modport source (
        output valid, best_x, best_y, best_z, best_score,
        input  ready
    );

    modport sink (
        input  valid, best_x, best_y, best_z, best_score,
        output ready
    );
endinterface

FILE: hw/rtl/bfcs_ctrl.sv
// Controller state machine for the best-fit candidate selector.
module bfcs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_cmd,
    output logic                   in_ready,
    input  bfcs_pkg::ctrl_status_t status,
    output bfcs_pkg::ctrl_cmd_t    cmd
);

    bfcs_pkg::state_t state_reg;
    bfcs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfcs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            bfcs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_cmd == bfcs_pkg::CMD_STORE)
                    begin
                        cmd.store_en = 1'b1;
                    end
                    else
                    begin
                        cmd.load_cand = 1'b1;
                        state_next    = bfcs_pkg::ST_SCAN;
                    end
                end
            end
            bfcs_pkg::ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                // A final candidate waits until the result slot can take it.
                if (status.scan_idle && !(status.cand_last && status.out_busy))
                begin
                    cmd.decide = 1'b1;
                    state_next = bfcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfcs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/bfcs_datapath.sv
// Datapath: point store, squared-distance pipeline, best tracker and result register.
module bfcs_datapath #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [COORD_BITS-1:0]  coord_x,
    input  logic signed [COORD_BITS-1:0]  coord_y,
    input  logic signed [COORD_BITS-1:0]  coord_z,
    input  logic                          last_candidate,
    input  bfcs_pkg::ctrl_cmd_t           cmd,
    output bfcs_pkg::ctrl_status_t        status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_BITS-1:0]  best_x,
    output logic signed [COORD_BITS-1:0]  best_y,
    output logic signed [COORD_BITS-1:0]  best_z,
    output logic [bfcs_pkg::SCORE_W-1:0]  best_score
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int ENT_W  = 3 * COORD_BITS;
    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int SUM_W  = SQ_W + 2;
    localparam int TOT_W  = (SUM_W + 1 > bfcs_pkg::SCORE_W + 1) ? SUM_W + 1
                                                                : bfcs_pkg::SCORE_W + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    logic [ENT_W-1:0] mem [0:MAX_POINTS-1];

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             rd_idx_reg;
    logic [ENT_W-1:0]             rd_data_reg;
    logic                         v1_reg;
    logic                         v2_reg;
    logic signed [COORD_BITS-1:0] cand_x_reg;
    logic signed [COORD_BITS-1:0] cand_y_reg;
    logic signed [COORD_BITS-1:0] cand_z_reg;
    logic                         cand_last_reg;
    logic [SQ_W-1:0]              sq_x_reg;
    logic [SQ_W-1:0]              sq_y_reg;
    logic [SQ_W-1:0]              sq_z_reg;
    logic [bfcs_pkg::SCORE_W-1:0] acc_reg;
    logic [bfcs_pkg::SCORE_W-1:0] lowest_reg;
    logic signed [COORD_BITS-1:0] bx_reg;
    logic signed [COORD_BITS-1:0] by_reg;
    logic signed [COORD_BITS-1:0] bz_reg;
    logic                         have_best_reg;
    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] out_x_reg;
    logic signed [COORD_BITS-1:0] out_y_reg;
    logic signed [COORD_BITS-1:0] out_z_reg;
    logic [bfcs_pkg::SCORE_W-1:0] out_score_reg;

    logic                         rd_issue;
    logic signed [COORD_BITS-1:0] rd_x;
    logic signed [COORD_BITS-1:0] rd_y;
    logic signed [COORD_BITS-1:0] rd_z;
    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic signed [COORD_BITS:0]   dz;
    logic signed [2*COORD_BITS+1:0] px;
    logic signed [2*COORD_BITS+1:0] py;
    logic signed [2*COORD_BITS+1:0] pz;
    logic [SUM_W-1:0]             dist_sum;
    logic [TOT_W-1:0]             acc_total;
    logic [bfcs_pkg::SCORE_W-1:0] acc_next;
    logic                         better;

    assign rd_issue = cmd.scan_en && (rd_idx_reg < count_reg);

    assign rd_x = rd_data_reg[3*COORD_BITS-1:2*COORD_BITS];
    assign rd_y = rd_data_reg[2*COORD_BITS-1:COORD_BITS];
    assign rd_z = rd_data_reg[COORD_BITS-1:0];

    assign dx = {cand_x_reg[COORD_BITS-1], cand_x_reg} - {rd_x[COORD_BITS-1], rd_x};
    assign dy = {cand_y_reg[COORD_BITS-1], cand_y_reg} - {rd_y[COORD_BITS-1], rd_y};
    assign dz = {cand_z_reg[COORD_BITS-1], cand_z_reg} - {rd_z[COORD_BITS-1], rd_z};
    assign px = dx * dx;
    assign py = dy * dy;
    assign pz = dz * dz;

    assign dist_sum  = {2'b00, sq_x_reg} + {2'b00, sq_y_reg} + {2'b00, sq_z_reg};
    assign acc_total = TOT_W'(acc_reg) + TOT_W'(dist_sum);
    assign acc_next  = (acc_total > TOT_W'(bfcs_pkg::SCORE_MAX)) ? bfcs_pkg::SCORE_MAX
                                                                 : acc_total[bfcs_pkg::SCORE_W-1:0];

    assign better = !have_best_reg || (acc_reg < lowest_reg);

    // Store port: written at the fill count, read at the scan index.
    always_ff @(posedge clk)
    begin
        if (cmd.store_en && (count_reg < CNT_MAX))
        begin
            mem[count_reg[ADDR_W-1:0]] <= {coord_x, coord_y, coord_z};
        end
        if (rd_issue)
        begin
            rd_data_reg <= mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_cand)
        begin
            cand_x_reg <= coord_x;
            cand_y_reg <= coord_y;
            cand_z_reg <= coord_z;
        end
        if (v1_reg)
        begin
            sq_x_reg <= px[SQ_W-1:0];
            sq_y_reg <= py[SQ_W-1:0];
            sq_z_reg <= pz[SQ_W-1:0];
        end
        if (cmd.load_cand)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.decide && cand_last_reg)
        begin
            out_x_reg     <= better ? cand_x_reg : bx_reg;
            out_y_reg     <= better ? cand_y_reg : by_reg;
            out_z_reg     <= better ? cand_z_reg : bz_reg;
            out_score_reg <= better ? acc_reg : lowest_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            cand_last_reg <= 1'b0;
            lowest_reg    <= bfcs_pkg::SCORE_MAX;
            bx_reg        <= '0;
            by_reg        <= '0;
            bz_reg        <= '0;
            have_best_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= rd_issue;
            v2_reg <= v1_reg;

            if (cmd.store_en && (count_reg < CNT_MAX))
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (cmd.load_cand)
            begin
                rd_idx_reg    <= '0;
                cand_last_reg <= last_candidate;
            end
            else if (rd_issue)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end

            if (out_valid_reg && out_ready && !(cmd.decide && cand_last_reg))
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.decide)
            begin
                if (cand_last_reg)
                begin
                    // End of batch: publish the winner and start afresh.
                    out_valid_reg <= 1'b1;
                    count_reg     <= '0;
                    lowest_reg    <= bfcs_pkg::SCORE_MAX;
                    bx_reg        <= '0;
                    by_reg        <= '0;
                    bz_reg        <= '0;
                    have_best_reg <= 1'b0;
                end
                else if (better)
                begin
                    lowest_reg    <= acc_reg;
                    bx_reg        <= cand_x_reg;
                    by_reg        <= cand_y_reg;
                    bz_reg        <= cand_z_reg;
                    have_best_reg <= 1'b1;
                end
            end
        end
    end

    assign status.scan_idle = (rd_idx_reg == count_reg) && !v1_reg && !v2_reg;
    assign status.cand_last = cand_last_reg;
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign best_x     = out_x_reg;
    assign best_y     = out_y_reg;
    assign best_z     = out_z_reg;
    assign best_score = out_score_reg;

endmodule

FILE: hw/rtl/best_fit_candidate_select.sv
// Timing: a cloud point is written at its accepting edge; a candidate occupies the block until
// the read, square and accumulate pipeline has run over every stored point, and a final
// candidate's result is registered when it is decided and is valid in the cycle after.
// Throughput: one stored point is scored per cycle during a scan; a final candidate also
// waits while an earlier result is still unread.
// Reset: controller, fill count, best tracker and result slot clear; the store is not cleared.
module best_fit_candidate_select #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    bfcs_item_if.sink    item,
    bfcs_result_if.source result
);

    // Commands from the controller and status back from the datapath.
    bfcs_pkg::ctrl_cmd_t    cmd;
    bfcs_pkg::ctrl_status_t status;

    // The controller accepts a transaction only when idle. A cloud point is written in the
    // accepting cycle, so cloud loading runs at one transaction per cycle. A candidate moves
    // the controller into its scan state, where the datapath walks the store one entry per
    // cycle through a read, square and accumulate pipeline.
    bfcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_cmd   (item.cmd),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The result sits in an output register with its own valid flag, so new transactions are
    // taken while a result is still waiting. Only a final candidate must wait for that slot.
    bfcs_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .coord_x        (item.coord_x),
        .coord_y        (item.coord_y),
        .coord_z        (item.coord_z),
        .last_candidate (item.last_candidate),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .best_x         (result.best_x),
        .best_y         (result.best_y),
        .best_z         (result.best_z),
        .best_score     (result.best_score)
    );

endmodule

FILE: tb/best_fit_candidate_select_tb.sv
// Self-checking testbench for the best-fit candidate selector: directed and random batches.
module best_fit_candidate_select_tb;

    localparam int MAX_POINTS  = 256;
    localparam int COORD_BITS  = 16;
    localparam int SCORE_W     = bfcs_pkg::SCORE_W;
    // A silent stretch this long means the block has hung; a correct run never gets near it.
    localparam int QUIET_LIMIT = 20000;
    // Length of the deliberate receiver hold-off that backs the block up into its input.
    localparam int HOLD_CYCLES = 1200;
    // Cycles to let pass after the last result, covering one full scan of the store.
    localparam int DRAIN_CYCLES = MAX_POINTS + 16;

    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = ~COORD_MIN;
    localparam longint unsigned SCORE_CAP = 64'(bfcs_pkg::SCORE_MAX);

    // One input transaction: a cloud point or a candidate point.
    typedef struct {
        logic                         cmd;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic                         last;
    } point_item_t;

    // The winner of a batch, as the block should report it.
    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [SCORE_W-1:0]           score;
    } batch_winner_t;

    logic clk = 1'b0;
    logic rst_n;

    bfcs_item_if   #(.COORD_BITS(COORD_BITS)) item_ch ();
    bfcs_result_if #(.COORD_BITS(COORD_BITS)) result_ch ();

    best_fit_candidate_select #(
        .MAX_POINTS(MAX_POINTS),
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    always #2 clk = ~clk;

    // Shared bookkeeping between the stimulus, the driver and the monitor.
    point_item_t   pending_items[$];
    batch_winner_t winner_q[$];
    point_item_t   offered;
    int            items_queued = 0;
    int            items_taken = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            holds_asked = 0;
    int            mismatch_count = 0;

    // Our own copy of the selector's state: the cloud, its fill count and the best so far.
    logic signed [COORD_BITS-1:0] cloud_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] cloud_y [MAX_POINTS];
    logic signed [COORD_BITS-1:0] cloud_z [MAX_POINTS];
    int unsigned                  cloud_count = 0;
    logic [SCORE_W-1:0]           lowest_score = bfcs_pkg::SCORE_MAX;
    logic signed [COORD_BITS-1:0] lead_x = '0;
    logic signed [COORD_BITS-1:0] lead_y = '0;
    logic signed [COORD_BITS-1:0] lead_z = '0;
    bit                           have_lead = 1'b0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Applies one accepted transaction to the model state. A final candidate appends the
    // expected winner of its batch and then clears the tracker and the fill count.
    task automatic absorb_item(input point_item_t it);
        longint          dx, dy, dz;
        longint unsigned dsq;
        longint unsigned total;
        int unsigned     i;
        batch_winner_t   win;
        if (it.cmd == bfcs_pkg::CMD_STORE)
        begin
            // Once the store is full, further cloud points are simply dropped.
            if (cloud_count < MAX_POINTS)
            begin
                cloud_x[cloud_count] = it.x;
                cloud_y[cloud_count] = it.y;
                cloud_z[cloud_count] = it.z;
                cloud_count++;
            end
            return;
        end
        total = 0;
        for (i = 0; i < cloud_count; i++)
        begin
            dx = longint'($signed(it.x)) - longint'($signed(cloud_x[i]));
            dy = longint'($signed(it.y)) - longint'($signed(cloud_y[i]));
            dz = longint'($signed(it.z)) - longint'($signed(cloud_z[i]));
            dsq = longint'(dx * dx + dy * dy + dz * dz);
            // The running sum saturates rather than wrapping.
            if (dsq > SCORE_CAP - total)
                total = SCORE_CAP;
            else
                total = total + dsq;
        end
        // Strictly lower wins, so the earliest of equal scores is kept; the first
        // candidate of a batch is always taken.
        if (!have_lead || total < 64'(lowest_score))
        begin
            lowest_score = SCORE_W'(total);
            lead_x = it.x;
            lead_y = it.y;
            lead_z = it.z;
            have_lead = 1'b1;
        end
        if (it.last)
        begin
            win.x = lead_x;
            win.y = lead_y;
            win.z = lead_z;
            win.score = lowest_score;
            winner_q.insert(winner_q.size(), win);
            cloud_count = 0;
            lowest_score = bfcs_pkg::SCORE_MAX;
            lead_x = '0;
            lead_y = '0;
            lead_z = '0;
            have_lead = 1'b0;
        end
    endtask

    // Driver: offers the next pending transaction, holding it steady until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid          <= 1'b0;
            item_ch.cmd            <= bfcs_pkg::CMD_STORE;
            item_ch.coord_x        <= '0;
            item_ch.coord_y        <= '0;
            item_ch.coord_z        <= '0;
            item_ch.last_candidate <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                absorb_item(offered);
                items_taken++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    offered = pending_items.pop_front();
                    item_ch.valid          <= 1'b1;
                    item_ch.cmd            <= offered.cmd;
                    item_ch.coord_x        <= offered.x;
                    item_ch.coord_y        <= offered.y;
                    item_ch.coord_z        <= offered.z;
                    item_ch.last_candidate <= offered.last;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result transaction against the oldest expected winner and
    // drives the result ready, including the long hold-off when one is requested.
    int holds_served = 0;
    int hold_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : monitor
        batch_winner_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (winner_q.size() == 0)
                begin
                    report_mismatch("result transaction with no batch outstanding");
                end
                else
                begin
                    want = winner_q.pop_front();
                    if (result_ch.best_x !== want.x)
                        report_mismatch($sformatf("best_x got %0d expected %0d",
                                                  result_ch.best_x, want.x));
                    if (result_ch.best_y !== want.y)
                        report_mismatch($sformatf("best_y got %0d expected %0d",
                                                  result_ch.best_y, want.y));
                    if (result_ch.best_z !== want.z)
                        report_mismatch($sformatf("best_z got %0d expected %0d",
                                                  result_ch.best_z, want.z));
                    if (result_ch.best_score !== want.score)
                        report_mismatch($sformatf("best_score got %0d expected %0d",
                                                  result_ch.best_score, want.score));
                end
            end
            if (holds_served != holds_asked)
            begin
                holds_served = holds_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: ends the run if neither channel completes a transaction for too long.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TIMEOUT: no transaction for %0d cycles", QUIET_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic queue_item(input logic cmd, input logic signed [COORD_BITS-1:0] x,
                              input logic signed [COORD_BITS-1:0] y,
                              input logic signed [COORD_BITS-1:0] z, input logic last);
        point_item_t it;
        it.cmd  = cmd;
        it.x    = x;
        it.y    = y;
        it.z    = z;
        it.last = last;
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endtask

    // A spread of zero means the whole range, with the extremes favoured; a small spread
    // keeps points close together so that equal scores turn up often.
    function automatic logic signed [COORD_BITS-1:0] pick_coord(input int spread);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return COORD_MIN;
        if (pick == 1)
            return COORD_MAX;
        if (spread == 0)
            return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
        return COORD_BITS'(int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // Queues one random batch. Most are well formed (cloud points, then candidates with the
    // last mark on the final one); the rest are noise with commands and marks at random.
    task automatic queue_batch();
        int kind;
        int spread;
        int n_pts;
        int n_cand;
        int k;
        kind = $urandom_range(0, 9);
        spread = (kind >= 6) ? 2 : 0;
        if (kind < 8)
        begin
            n_pts = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(0, 10);
            n_cand = $urandom_range(1, 5);
            for (k = 0; k < n_pts; k++)
                queue_item(bfcs_pkg::CMD_STORE, pick_coord(spread), pick_coord(spread),
                           pick_coord(spread), 1'($urandom_range(0, 1)));
            for (k = 0; k < n_cand; k++)
                queue_item(bfcs_pkg::CMD_EVAL, pick_coord(spread), pick_coord(spread),
                           pick_coord(spread), k == n_cand - 1);
        end
        else
        begin
            n_pts = $urandom_range(1, 12);
            for (k = 0; k < n_pts; k++)
                queue_item(1'($urandom_range(0, 1)), pick_coord(0), pick_coord(0),
                           pick_coord(0), $urandom_range(0, 3) == 0);
        end
    endtask

    // Pauses the sender until every queued transaction has been taken and every expected
    // result has arrived.
    task automatic settle();
        while (items_taken != items_queued || winner_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
        int target;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        target = items_queued + n_items;
        while (items_queued < target)
            queue_batch();
        settle();
    endtask

    initial
    begin : stimulus
        int k;
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.cmd = bfcs_pkg::CMD_STORE;
        item_ch.coord_x = '0;
        item_ch.coord_y = '0;
        item_ch.coord_z = '0;
        item_ch.last_candidate = 1'b0;
        result_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty cloud: every candidate scores zero and the first one wins.
        queue_item(bfcs_pkg::CMD_EVAL, 16'sd5, -16'sd3, 16'sd7, 1'b0);
        queue_item(bfcs_pkg::CMD_EVAL, -16'sd1, 16'sd2, 16'sd3, 1'b1);
        // A last mark on a cloud point is ignored; equal scores keep the earliest candidate.
        queue_item(bfcs_pkg::CMD_STORE, '0, '0, '0, 1'b1);
        queue_item(bfcs_pkg::CMD_EVAL, 16'sd1, '0, '0, 1'b0);
        queue_item(bfcs_pkg::CMD_EVAL, -16'sd1, '0, '0, 1'b0);
        queue_item(bfcs_pkg::CMD_EVAL, '0, '0, 16'sd1, 1'b1);
        // Extreme coordinates, largest distances in both directions.
        queue_item(bfcs_pkg::CMD_STORE, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        queue_item(bfcs_pkg::CMD_STORE, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        queue_item(bfcs_pkg::CMD_EVAL, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        queue_item(bfcs_pkg::CMD_EVAL, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        queue_item(bfcs_pkg::CMD_EVAL, '0, '0, '0, 1'b1);
        // Mixed extremes and alternating bit patterns.
        queue_item(bfcs_pkg::CMD_STORE, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        queue_item(bfcs_pkg::CMD_STORE, -16'sd1, -16'sd1, -16'sd1, 1'b0);
        queue_item(bfcs_pkg::CMD_STORE, 16'sh5555, 16'shaaaa, 16'sh5555, 1'b0);
        queue_item(bfcs_pkg::CMD_EVAL, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        queue_item(bfcs_pkg::CMD_EVAL, 16'shaaaa, 16'sh5555, 16'shaaaa, 1'b0);
        queue_item(bfcs_pkg::CMD_EVAL, COORD_MIN, COORD_MIN, COORD_MAX, 1'b1);
        settle();

        // Fill the store past its capacity so the surplus cloud points are dropped, then
        // score candidates against a completely full store.
        for (k = 0; k < MAX_POINTS + 2; k++)
            queue_item(bfcs_pkg::CMD_STORE, pick_coord(0), pick_coord(0), pick_coord(0), 1'b0);
        queue_item(bfcs_pkg::CMD_EVAL, pick_coord(0), pick_coord(0), pick_coord(0), 1'b0);
        queue_item(bfcs_pkg::CMD_EVAL, pick_coord(0), pick_coord(0), pick_coord(0), 1'b1);
        settle();

        run_phase(0, 0, 150);
        run_phase(62, 0, 200);
        // The receiver holds off for a long stretch at the start of this phase while the
        // sender keeps offering, so the block backs up and stalls its input.
        holds_asked++;
        run_phase(0, 62, 200);
        run_phase(8, 8, 200);
        run_phase(0, 0, 100);

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (winner_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", winner_q.size()));
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
